@@ design/ktoc_pkg.sv @@
`timescale 1ns / 1ps

package ktoc_pkg;

  localparam int KEY_W  = 16;
  localparam int KIND_W = 2;
  localparam int SYM_W  = 4;
  localparam int COL_W  = 4;
  localparam int VAL_W  = 16;
  localparam int OPND_W = 14;
  localparam int CNT_W  = 3;
  localparam int KNUM_W = 5;

  localparam logic [SYM_W-1:0] SYM_PLUS   = 4'd10;
  localparam logic [SYM_W-1:0] SYM_MINUS  = 4'd11;
  localparam logic [SYM_W-1:0] SYM_EQUALS = 4'd12;
  localparam logic [SYM_W-1:0] SYM_NONE   = 4'd15;
  localparam logic [SYM_W-1:0] SYM_MAX_DIGIT = 4'd9;

  localparam logic [KIND_W-1:0] EV_ECHO   = 2'd0;
  localparam logic [KIND_W-1:0] EV_RESULT = 2'd1;
  localparam logic [KIND_W-1:0] EV_CLEAR  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]       event_kind;
    logic [SYM_W-1:0]        echo_symbol;
    logic [COL_W-1:0]        echo_column;
    logic signed [VAL_W-1:0] result_value;
  } ktoc_result_t;

  // Key number 1..16 to symbol; zero means no key was pressed.
  function automatic logic [SYM_W-1:0] key_symbol(input logic [KNUM_W-1:0] key);
    logic [SYM_W-1:0] sym;
    unique case (key)
      5'd1:    sym = 4'd7;
      5'd2:    sym = 4'd8;
      5'd3:    sym = 4'd9;
      5'd4:    sym = SYM_MINUS;
      5'd5:    sym = 4'd4;
      5'd6:    sym = 4'd5;
      5'd7:    sym = 4'd6;
      5'd8:    sym = SYM_PLUS;
      5'd9:    sym = 4'd1;
      5'd10:   sym = 4'd2;
      5'd11:   sym = 4'd3;
      5'd14:   sym = 4'd0;
      5'd16:   sym = SYM_EQUALS;
      default: sym = SYM_NONE;
    endcase
    return sym;
  endfunction

endpackage

@@ design/ktoc_channels.sv @@
`timescale 1ns / 1ps

interface ktoc_in_if import ktoc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] pressed_keys;

  modport source (output valid, output pressed_keys, input ready);
  modport sink   (input valid, input pressed_keys, output ready);
endinterface

interface ktoc_out_if import ktoc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       event_kind;
  logic [SYM_W-1:0]        echo_symbol;
  logic [COL_W-1:0]        echo_column;
  logic signed [VAL_W-1:0] result_value;

  modport source (output valid, output event_kind, output echo_symbol,
                  output echo_column, output result_value, input ready);
  modport sink   (input valid, input event_kind, input echo_symbol,
                  input echo_column, input result_value, output ready);
endinterface

@@ design/ktoc_key_decode.sv @@
`timescale 1ns / 1ps

module ktoc_key_decode import ktoc_pkg::*; (
  input  logic [KEY_W-1:0] pressed_keys,
  output logic [SYM_W-1:0] symbol
);

  logic [KNUM_W-1:0] key;

  // The highest column wins, then the lowest row: later assignments take priority.
  always_comb begin
    key = '0;
    for (int c = 1; c <= 4; c++) begin
      for (int r = 3; r >= 0; r--) begin
        if (pressed_keys[c + 4 * r - 1]) begin
          key = KNUM_W'(c + 4 * r);
        end
      end
    end
  end

  assign symbol = key_symbol(key);

endmodule

@@ design/ktoc_calc.sv @@
`timescale 1ns / 1ps

module ktoc_calc import ktoc_pkg::*; #(
  parameter int MAX_DIGITS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [SYM_W-1:0] symbol,
  output logic             emit,
  output ktoc_result_t     res
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_SHOWN  = 2'd2
  } phase_t;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

  phase_t            phase_r, phase_nxt;
  logic [OPND_W-1:0] first_r, first_nxt;
  logic [OPND_W-1:0] second_r, second_nxt;
  logic [CNT_W-1:0]  first_cnt_r, first_cnt_nxt;
  logic [CNT_W-1:0]  second_cnt_r, second_cnt_nxt;
  logic              sub_r, sub_nxt;

  logic              is_digit;
  logic [OPND_W+2:0] first_mac;
  logic [OPND_W+2:0] second_mac;
  logic [COL_W-1:0]  second_col;
  logic [VAL_W-1:0]  calc_value;

  assign is_digit   = (symbol <= SYM_MAX_DIGIT);
  assign first_mac  = {first_r, 3'b000} + {2'b00, first_r, 1'b0} + (OPND_W+3)'(symbol);
  assign second_mac = {second_r, 3'b000} + {2'b00, second_r, 1'b0} + (OPND_W+3)'(symbol);
  assign second_col = COL_W'(first_cnt_r) + COL_W'(second_cnt_r) + COL_W'(1);
  assign calc_value = sub_r ? (VAL_W'(first_r) - VAL_W'(second_r))
                            : (VAL_W'(first_r) + VAL_W'(second_r));

  always_comb begin
    phase_nxt      = phase_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    sub_nxt        = sub_r;
    emit           = 1'b0;
    res.event_kind   = EV_ECHO;
    res.echo_symbol  = symbol;
    res.echo_column  = '0;
    res.result_value = '0;
    if (symbol != SYM_NONE) begin
      unique case (phase_r)
        PH_FIRST: begin
          if (is_digit) begin
            if (first_cnt_r < MAX_CNT) begin
              first_nxt       = first_mac[OPND_W-1:0];
              first_cnt_nxt   = first_cnt_r + CNT_W'(1);
              emit            = 1'b1;
              res.echo_column = COL_W'(first_cnt_r);
            end
          end else if (symbol == SYM_PLUS || symbol == SYM_MINUS) begin
            sub_nxt         = (symbol == SYM_MINUS);
            phase_nxt       = PH_SECOND;
            emit            = 1'b1;
            res.echo_column = COL_W'(first_cnt_r);
          end
        end
        PH_SECOND: begin
          if (is_digit) begin
            if (second_cnt_r < MAX_CNT) begin
              second_nxt      = second_mac[OPND_W-1:0];
              second_cnt_nxt  = second_cnt_r + CNT_W'(1);
              emit            = 1'b1;
              res.echo_column = second_col;
            end
          end else if (symbol == SYM_EQUALS) begin
            phase_nxt        = PH_SHOWN;
            emit             = 1'b1;
            res.event_kind   = EV_RESULT;
            res.echo_column  = second_col;
            res.result_value = calc_value;
          end
        end
        default: begin
          if (symbol == SYM_EQUALS) begin
            phase_nxt      = PH_FIRST;
            first_nxt      = '0;
            second_nxt     = '0;
            first_cnt_nxt  = '0;
            second_cnt_nxt = '0;
            sub_nxt        = 1'b0;
            emit           = 1'b1;
            res.event_kind = EV_CLEAR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIRST;
      first_r      <= '0;
      second_r     <= '0;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      sub_r        <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      sub_r        <= sub_nxt;
    end
  end

endmodule

@@ design/keypad_two_operand_calculator_unit.sv @@
`timescale 1ns / 1ps
// A result item passes the input register, then the result register; while the result
// register is stalled, the buffered scan is held in the input register.
// Throughput: one scan per cycle while the result register is not stalled; the calculator
// state updates on each accepted step. Ignored scans produce no item.
// Reset (synchronous, active low): both registers empty, first operand entry.

module keypad_two_operand_calculator_unit import ktoc_pkg::*; #(
  parameter int MAX_DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  ktoc_in_if.sink           in_ch,
  ktoc_out_if.source        out_ch
);

  logic             s1_valid_r;
  logic [KEY_W-1:0] s1_keys_r;
  logic             out_valid_r;
  ktoc_result_t     out_r;

  logic             advance;
  logic             step;
  logic [SYM_W-1:0] symbol;
  logic             emit;
  ktoc_result_t     res;

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  ktoc_key_decode u_decode (
    .pressed_keys (s1_keys_r),
    .symbol       (symbol)
  );

  ktoc_calc #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .symbol (symbol),
    .emit   (emit),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_keys_r <= in_ch.pressed_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_r.event_kind;
  assign out_ch.echo_symbol  = out_r.echo_symbol;
  assign out_ch.echo_column  = out_r.echo_column;
  assign out_ch.result_value = out_r.result_value;

`ifndef NO_ASSERTIONS
  a_stalled_scan_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_keys_r))
    else $error("Buffered scan lost while the result register was stalled.");

  a_clear_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_kind == EV_CLEAR |->
      out_r.echo_column == '0 && out_r.result_value == '0 && out_r.echo_symbol == SYM_EQUALS)
    else $error("Clear item carries a nonzero column or value.");

  a_echo_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_kind == EV_ECHO |->
      out_r.result_value == '0 && out_r.echo_column <= COL_W'(9))
    else $error("Echo item carries a value or an out-of-range column.");

  a_result_is_equals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_kind == EV_RESULT |-> out_r.echo_symbol == SYM_EQUALS)
    else $error("Result item not caused by the equals key.");
`endif

endmodule

@@ test/keypad_two_operand_calculator_unit_tb.sv @@
`timescale 1ns / 1ps

module keypad_two_operand_calculator_unit_tb;
  import ktoc_pkg::*;

  localparam int CALC_DIGITS   = 4;
  localparam int RANDOM_SCANS  = 1150;
  localparam int DIRECTED_ROWS = 26;

  typedef enum logic [1:0] {
    ENTER_LHS,
    ENTER_RHS,
    SHOW_RESULT,
    PHASE_SPARE
  } calc_phase_e;

  typedef enum logic [1:0] {
    ROW_IGNORED,
    ROW_TYPED,
    ROW_PREDICTED
  } row_kind_e;

  typedef struct packed {
    logic [KEY_W-1:0] keys;
    row_kind_e        kind;
    ktoc_result_t     want;
  } scan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ktoc_in_if  in_ch ();
  ktoc_out_if out_ch ();

  keypad_two_operand_calculator_unit #(
    .MAX_DIGITS(CALC_DIGITS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  calc_phase_e        calc_phase;
  logic [OPND_W-1:0]  lhs_value;
  logic [OPND_W-1:0]  rhs_value;
  logic [CNT_W-1:0]   lhs_digits;
  logic [CNT_W-1:0]   rhs_digits;
  logic               minus_op;

  ktoc_result_t expected_events[$];
  scan_row_t    directed_scans [DIRECTED_ROWS];
  int           errors = 0;
  int           scans_fed = 0;
  bit           in_calm = 1'b0;
  bit           out_calm = 1'b0;

  function automatic logic [KNUM_W-1:0] pick_key(input logic [KEY_W-1:0] keys);
    int col;
    int row;
    int k;
    for (col = 4; col >= 1; col--) begin
      for (row = 0; row < 4; row++) begin
        k = col + 4 * row;
        if (keys[k-1]) begin
          return KNUM_W'(k);
        end
      end
    end
    return '0;
  endfunction

  function automatic logic [SYM_W-1:0] key_to_symbol(input logic [KNUM_W-1:0] key);
    case (key)
      5'd1:    return 4'd7;
      5'd2:    return 4'd8;
      5'd3:    return 4'd9;
      5'd4:    return SYM_MINUS;
      5'd5:    return 4'd4;
      5'd6:    return 4'd5;
      5'd7:    return 4'd6;
      5'd8:    return SYM_PLUS;
      5'd9:    return 4'd1;
      5'd10:   return 4'd2;
      5'd11:   return 4'd3;
      5'd14:   return 4'd0;
      5'd16:   return SYM_EQUALS;
      default: return SYM_NONE;
    endcase
  endfunction

  function automatic logic [KNUM_W-1:0] key_for_symbol(input logic [SYM_W-1:0] sym);
    int k;
    for (k = 1; k <= 16; k++) begin
      if (key_to_symbol(KNUM_W'(k)) == sym) begin
        return KNUM_W'(k);
      end
    end
    return '0;
  endfunction

  // Extra keys are only added where the scan order ranks them below the chosen key.
  function automatic logic [KEY_W-1:0] scan_for(input logic [KNUM_W-1:0] key, input bit noisy);
    logic [KEY_W-1:0] keys;
    int               own_rank;
    int               j;
    keys     = '0;
    keys[key-1] = 1'b1;
    own_rank = (3 - (key - 1) % 4) * 4 + (key - 1) / 4;
    if (noisy) begin
      for (j = 1; j <= 16; j++) begin
        if (((3 - (j - 1) % 4) * 4 + (j - 1) / 4) > own_rank && $urandom_range(0, 1)) begin
          keys[j-1] = 1'b1;
        end
      end
    end
    return keys;
  endfunction

  function automatic void clear_calculator();
    calc_phase = ENTER_LHS;
    lhs_value  = '0;
    rhs_value  = '0;
    lhs_digits = '0;
    rhs_digits = '0;
    minus_op   = 1'b0;
  endfunction

  function automatic bit predict_event(input logic [KEY_W-1:0] keys, output ktoc_result_t ev);
    logic [SYM_W-1:0] sym;
    logic [VAL_W-1:0] lhs_wide;
    logic [VAL_W-1:0] rhs_wide;
    ev  = '0;
    sym = key_to_symbol(pick_key(keys));
    if (sym == SYM_NONE) begin
      return 1'b0;
    end
    case (calc_phase)
      ENTER_LHS: begin
        if (sym <= SYM_MAX_DIGIT) begin
          if (lhs_digits >= CALC_DIGITS) begin
            return 1'b0;
          end
          ev.event_kind  = EV_ECHO;
          ev.echo_symbol = sym;
          ev.echo_column = COL_W'(lhs_digits);
          lhs_value  = OPND_W'(lhs_value * 10 + sym);
          lhs_digits = lhs_digits + 1'b1;
          return 1'b1;
        end
        if (sym == SYM_PLUS || sym == SYM_MINUS) begin
          minus_op       = (sym == SYM_MINUS);
          calc_phase     = ENTER_RHS;
          ev.event_kind  = EV_ECHO;
          ev.echo_symbol = sym;
          ev.echo_column = COL_W'(lhs_digits);
          return 1'b1;
        end
        return 1'b0;
      end
      ENTER_RHS: begin
        ev.echo_column = COL_W'(lhs_digits) + COL_W'(rhs_digits) + 4'd1;
        ev.echo_symbol = sym;
        if (sym <= SYM_MAX_DIGIT) begin
          if (rhs_digits >= CALC_DIGITS) begin
            return 1'b0;
          end
          ev.event_kind = EV_ECHO;
          rhs_value  = OPND_W'(rhs_value * 10 + sym);
          rhs_digits = rhs_digits + 1'b1;
          return 1'b1;
        end
        if (sym == SYM_EQUALS) begin
          lhs_wide        = VAL_W'(lhs_value);
          rhs_wide        = VAL_W'(rhs_value);
          ev.event_kind   = EV_RESULT;
          ev.result_value = minus_op ? lhs_wide - rhs_wide : lhs_wide + rhs_wide;
          calc_phase      = SHOW_RESULT;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (sym == SYM_EQUALS) begin
          clear_calculator();
          ev.event_kind  = EV_CLEAR;
          ev.echo_symbol = SYM_EQUALS;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic offer_scan(input logic [KEY_W-1:0] keys);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 39) == 0) begin
      in_calm = !in_calm;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pressed_keys <= keys;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic feed(input logic [KEY_W-1:0] keys);
    ktoc_result_t ev;
    offer_scan(keys);
    scans_fed++;
    if (predict_event(keys, ev)) begin
      expected_events.push_back(ev);
    end
  endtask

  task automatic feed_key(input logic [KNUM_W-1:0] key);
    feed(scan_for(key, $urandom_range(0, 1)));
  endtask

  task automatic enter_operand();
    bit all_nines;
    int count;
    all_nines = ($urandom_range(0, 3) == 0);
    count     = $urandom_range(0, CALC_DIGITS + 1);
    repeat (count) begin
      feed_key(key_for_symbol(all_nines ? SYM_MAX_DIGIT : SYM_W'($urandom_range(0, 9))));
    end
  endtask

  task automatic run_calculation();
    enter_operand();
    feed_key(key_for_symbol($urandom_range(0, 1) ? SYM_PLUS : SYM_MINUS));
    enter_operand();
    feed_key(key_for_symbol(SYM_EQUALS));
    if ($urandom_range(0, 4) == 0) begin
      feed_key(KNUM_W'($urandom_range(1, 15)));
    end
    feed_key(key_for_symbol(SYM_EQUALS));
  endtask

  task automatic check_event();
    ktoc_result_t got;
    ktoc_result_t want;
    got.event_kind   = out_ch.event_kind;
    got.echo_symbol  = out_ch.echo_symbol;
    got.echo_column  = out_ch.echo_column;
    got.result_value = out_ch.result_value;
    if (expected_events.size() == 0) begin
      errors++;
      $display("%0t: expected no item, got kind=%0d sym=%0d col=%0d val=%0d", $time,
               got.event_kind, got.echo_symbol, got.echo_column, got.result_value);
      return;
    end
    want = expected_events.pop_front();
    if (got.event_kind !== want.event_kind || got.echo_symbol !== want.echo_symbol ||
        got.echo_column !== want.echo_column || got.result_value !== want.result_value) begin
      errors++;
      $display("%0t: expected kind=%0d sym=%0d col=%0d val=%0d, %s",
               $time, want.event_kind, want.echo_symbol, want.echo_column,
               want.result_value,
               $sformatf("got kind=%0d sym=%0d col=%0d val=%0d", got.event_kind,
                         got.echo_symbol, got.echo_column, got.result_value));
    end
  endtask

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = out_calm ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 39) == 0) begin
        out_calm = !out_calm;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      check_event();
    end
  end

  initial begin
    ktoc_result_t ev;
    int           i;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.pressed_keys <= '0;
    clear_calculator();
    directed_scans = '{
      '{16'h0000, ROW_IGNORED,   '0},
      '{16'h1000, ROW_IGNORED,   '0},
      '{16'h4000, ROW_IGNORED,   '0},
      '{16'h8000, ROW_IGNORED,   '0},
      '{16'h0004, ROW_TYPED,     '{EV_ECHO, 4'd9, 4'd0, 16'sd0}},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h0004, ROW_IGNORED,   '0},
      '{16'h0080, ROW_TYPED,     '{EV_ECHO, SYM_PLUS, 4'd4, 16'sd0}},
      '{16'h0008, ROW_IGNORED,   '0},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h0004, ROW_IGNORED,   '0},
      '{16'h8000, ROW_TYPED,     '{EV_RESULT, SYM_EQUALS, 4'd9, 16'sd19998}},
      '{16'h8000, ROW_TYPED,     '{EV_CLEAR, SYM_EQUALS, 4'd0, 16'sd0}},
      '{16'hFFFF, ROW_TYPED,     '{EV_ECHO, SYM_MINUS, 4'd0, 16'sd0}},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h0004, ROW_PREDICTED, '0},
      '{16'h8000, ROW_TYPED,     '{EV_RESULT, SYM_EQUALS, 4'd5, -16'sd9999}},
      '{16'hFFFF, ROW_IGNORED,   '0},
      '{16'h8000, ROW_TYPED,     '{EV_CLEAR, SYM_EQUALS, 4'd0, 16'sd0}}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      offer_scan(directed_scans[i].keys);
      if (predict_event(directed_scans[i].keys, ev) &&
          directed_scans[i].kind == ROW_PREDICTED) begin
        expected_events.push_back(ev);
      end
      if (directed_scans[i].kind == ROW_TYPED) begin
        expected_events.push_back(directed_scans[i].want);
      end
    end

    scans_fed = 0;
    while (scans_fed < RANDOM_SCANS) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0:       feed(KEY_W'($urandom));
            1:       feed('0);
            2:       feed_key(5'd13);
            default: feed_key(5'd15);
          endcase
        end
        1:       feed_key(KNUM_W'($urandom_range(1, 16)));
        default: run_calculation();
      endcase
    end

    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
